// ----- hw/rtl/bpa_pkg.sv -----
// Package for the buddy page allocator: sizes, command and status codes,
// register indexes and shared types. No dependencies.
`default_nettype none
package bpa_pkg;

  localparam int NUM_PAGES = 4096;
  localparam int TOP_ORDER = 10;

  localparam int OFS_W  = 12;  // page offset inside the zone
  localparam int LINK_W = 13;  // offset or null
  localparam int ORD_W  = 4;
  localparam int PAGE_W = 20;
  localparam int END_W  = 21;
  localparam int CNT_W  = 13;
  localparam int FLAG_W = ORD_W + 1;  // free bit over block order

  localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_PAGES);

  typedef logic [OFS_W-1:0]  ofs_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [ORD_W-1:0]  ord_t;
  typedef logic [END_W-1:0]  wpage_t;

  // Command codes
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_ADD   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOBLK = 2'd1;
  localparam logic [1:0] ST_ZONE  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_ZONE_FIRST = 1'b0;
  localparam logic CFG_ZONE_COUNT = 1'b1;

endpackage
`default_nettype wire

// ----- hw/rtl/bpa_req_if.sv -----
// Request channel of the buddy page allocator.
// Depends on bpa_pkg.
`default_nettype none
interface bpa_req_if;
  import bpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [ORD_W-1:0]  block_order;
  logic [PAGE_W-1:0] page_index;
  logic [END_W-1:0]  range_end;

  modport source (output valid, cmd, block_order, page_index, range_end, input ready);
  modport sink (input valid, cmd, block_order, page_index, range_end, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bpa_rsp_if.sv -----
// Response channel of the buddy page allocator.
// Depends on bpa_pkg.
`default_nettype none
interface bpa_rsp_if;
  import bpa_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [PAGE_W-1:0] block_page;

  modport source (output valid, status, block_page, input ready);
  modport sink (input valid, status, block_page, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/bpa_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read in the write cycle returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hw/rtl/buddy_page_allocator_top.sv -----
// Buddy page allocator over one zone of up to 4096 pages, orders 0 to 10.
// After reset the block runs a clearing pass over all 4096 entries of the page
// state memory, marking every page busy; requests wait, configuration writes
// are taken. Each request then takes one response, and a new request is taken
// only once the previous response has been accepted. A rejected request goes
// straight to its response; an allocate searches the lists upward from the
// requested order, then splits, listing each split half that lies in the zone;
// a free of a page that already heads a free block is left alone, any other
// free merges step by step with free buddies; an add range lists each aligned
// block of the range that is not already free. Steps that read the page
// memories (free flag and order, next link, previous link) wait on their
// registered read.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if and bpa_ram.
`default_nettype none
module buddy_page_allocator_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [bpa_pkg::PAGE_W-1:0]   cfg_wdata,
  bpa_req_if.sink                           req,
  bpa_rsp_if.source                         rsp
);
  import bpa_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_WAIT, S_A_SEARCH, S_UNLINK, S_SPLIT,
    S_PUSH_H, S_PUSH_H2, S_F_CHK, S_F_MERGE, S_F_BCHK,
    S_ADD_BLK, S_ADD_CHK, S_ADD_T2, S_DONE
  } state_t;

  state_t            state, ret;
  logic [PAGE_W-1:0] zone_first;
  logic [CNT_W-1:0]  zone_cnt_reg;
  link_t             head [TOP_ORDER+1];
  link_t             tail [TOP_ORDER+1];
  logic [1:0]        cmd_q;
  ord_t              ord, tgt;
  wpage_t            pg, bd, end_q;
  ofs_t              nd, off, clr;
  link_t             link_save;
  logic [1:0]        stat;
  logic [PAGE_W-1:0] page_out;
  logic              out_v;

  // Memory ports
  logic              flag_we, next_we, prev_we;
  ofs_t              flag_wa, next_wa, prev_wa;
  logic [FLAG_W-1:0] flag_wd, flag_rd;
  link_t             next_wd, prev_wd, next_rd, prev_rd;

  bpa_ram #(.WIDTH(FLAG_W), .DEPTH(NUM_PAGES)) u_flag_ram (
    .clk(clk), .we(flag_we), .waddr(flag_wa), .wdata(flag_wd), .raddr(nd), .rdata(flag_rd)
  );
  bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_next_ram (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd), .raddr(nd), .rdata(next_rd)
  );
  bpa_ram #(.WIDTH(LINK_W), .DEPTH(NUM_PAGES)) u_prev_ram (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd), .raddr(nd), .rdata(prev_rd)
  );

  // Zone bounds, with the page count clamped to the memory depth.
  logic [CNT_W-1:0] zcnt;
  wpage_t           zone_lo, zone_end;
  assign zcnt     = (zone_cnt_reg > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : zone_cnt_reg;
  assign zone_lo  = {1'b0, zone_first};
  assign zone_end = zone_lo + END_W'(zcnt);

  function automatic logic in_zone(input wpage_t p, input wpage_t lo, input logic [CNT_W-1:0] c);
    wpage_t d;
    d = p - lo;
    return (p >= lo) && (d < END_W'(c));
  endfunction

  // Request decode
  wpage_t req_page;
  ofs_t   req_ofs;
  assign req_page = {1'b0, req.page_index};
  assign req_ofs  = OFS_W'(req_page - zone_lo);

  // Buddy of the current block at the current order, or at the order below while splitting.
  wpage_t step, buddy;
  ofs_t   buddy_ofs;
  ord_t   ord_dn;
  assign ord_dn    = ord - ORD_W'(1);
  assign step      = (state == S_SPLIT) ? (END_W'(1) << ord_dn) : (END_W'(1) << ord);
  assign buddy     = pg ^ step;
  assign buddy_ofs = OFS_W'(buddy - zone_lo);

  // Largest aligned block at pg that stays below end_q.
  ord_t   add_k;
  logic   add_found;
  wpage_t pg_next;
  always_comb begin
    add_k     = ORD_W'(TOP_ORDER);
    add_found = 1'b0;
    for (int k = 0; k < TOP_ORDER; k++) begin
      if (!add_found && (pg[k] || ({1'b0, pg} + (22'd2 << k)) > {1'b0, end_q})) begin
        add_k     = ORD_W'(k);
        add_found = 1'b1;
      end
    end
  end
  assign pg_next = pg + (END_W'(1) << ord);

  // Unlink data read for node nd.
  logic ul_prev_ok, ul_next_ok;
  assign ul_prev_ok = prev_rd < NIL;
  assign ul_next_ok = next_rd < NIL;

  // A new request waits until the previous response has been taken.
  assign req.ready      = (state == S_IDLE) && !out_v;
  assign rsp.valid      = out_v;
  assign rsp.status     = stat;
  assign rsp.block_page = page_out;

  // Memory write control.
  always_comb begin
    flag_we = 1'b0;
    flag_wa = nd;
    flag_wd = '0;
    next_we = 1'b0;
    next_wa = nd;
    next_wd = NIL;
    prev_we = 1'b0;
    prev_wa = nd;
    prev_wd = NIL;
    unique case (state)
      S_CLEAR: begin
        flag_we = 1'b1;
        flag_wa = clr;
      end
      S_UNLINK: begin
        flag_we = 1'b1;
        next_we = ul_prev_ok;
        next_wa = OFS_W'(prev_rd);
        next_wd = next_rd;
        prev_we = ul_next_ok;
        prev_wa = OFS_W'(next_rd);
        prev_wd = prev_rd;
      end
      S_PUSH_H: begin
        flag_we = 1'b1;
        flag_wd = {1'b1, ord};
        next_we = 1'b1;
        next_wd = head[ord];
        prev_we = 1'b1;
      end
      S_PUSH_H2: begin
        prev_we = link_save < NIL;
        prev_wa = OFS_W'(link_save);
        prev_wd = LINK_W'(nd);
      end
      S_ADD_CHK: begin
        flag_we = !flag_rd[FLAG_W-1];
        flag_wd = {1'b1, ord};
        next_we = !flag_rd[FLAG_W-1];
        prev_we = !flag_rd[FLAG_W-1];
        prev_wd = tail[ord];
      end
      S_ADD_T2: begin
        next_we = link_save < NIL;
        next_wa = OFS_W'(link_save);
        next_wd = LINK_W'(nd);
      end
      default: begin
      end
    endcase
  end

  // Sequencer, list heads and tails, response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      ret          <= S_IDLE;
      clr          <= '0;
      out_v        <= 1'b0;
      zone_first   <= '0;
      zone_cnt_reg <= CNT_W'(NUM_PAGES);
      for (int k = 0; k <= TOP_ORDER; k++) begin
        head[k] <= NIL;
        tail[k] <= NIL;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ZONE_FIRST: zone_first   <= cfg_wdata;
          CFG_ZONE_COUNT: zone_cnt_reg <= cfg_wdata[CNT_W-1:0];
          default: ;
        endcase
      end

      // Response valid is set when a result is handed over and cleared when taken.
      if (state == S_DONE && (!out_v || rsp.ready)) begin
        out_v <= 1'b1;
      end else if (rsp.ready) begin
        out_v <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr <= clr + OFS_W'(1);
          if (&clr) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (req.valid && !out_v) begin
            cmd_q    <= req.cmd;
            ord      <= req.block_order;
            tgt      <= req.block_order;
            page_out <= '0;
            unique case (req.cmd)
              CMD_ALLOC: begin
                if (req.block_order > ORD_W'(TOP_ORDER)) begin
                  stat  <= ST_NOBLK;
                  state <= S_DONE;
                end else begin
                  stat  <= ST_OK;
                  state <= S_A_SEARCH;
                end
              end
              CMD_FREE: begin
                if (!in_zone(req_page, zone_lo, zcnt)) begin
                  stat  <= ST_ZONE;
                  state <= S_DONE;
                end else if (req.block_order > ORD_W'(TOP_ORDER)) begin
                  stat  <= ST_NOBLK;
                  state <= S_DONE;
                end else begin
                  stat  <= ST_OK;
                  pg    <= req_page;
                  off   <= req_ofs;
                  nd    <= req_ofs;
                  ret   <= S_F_CHK;
                  state <= S_WAIT;
                end
              end
              CMD_ADD: begin
                if (req_page >= req.range_end) begin
                  stat  <= ST_OK;
                  state <= S_DONE;
                end else if (!in_zone(req_page, zone_lo, zcnt) || req.range_end > zone_end) begin
                  stat  <= ST_ZONE;
                  state <= S_DONE;
                end else begin
                  stat  <= ST_OK;
                  pg    <= req_page;
                  end_q <= req.range_end;
                  state <= S_ADD_BLK;
                end
              end
              default: begin
                stat  <= ST_OK;
                state <= S_DONE;
              end
            endcase
          end
        end

        S_WAIT: state <= ret;

        // Find the smallest non-empty list at or above the requested order.
        S_A_SEARCH: begin
          if (ord > ORD_W'(TOP_ORDER)) begin
            stat  <= ST_NOBLK;
            state <= S_DONE;
          end else if (head[ord] == NIL) begin
            ord <= ord + ORD_W'(1);
          end else begin
            nd    <= OFS_W'(head[ord]);
            ret   <= S_UNLINK;
            state <= S_WAIT;
          end
        end

        // Take node nd off list ord and mark it busy.
        S_UNLINK: begin
          if (!ul_prev_ok) head[ord] <= next_rd;
          if (!ul_next_ok) tail[ord] <= prev_rd;
          if (cmd_q == CMD_ALLOC) begin
            pg    <= zone_lo + END_W'(nd);
            state <= S_SPLIT;
          end else begin
            ord   <= ord + ORD_W'(1);
            if (bd < pg) begin
              pg  <= bd;
              off <= nd;
            end
            state <= S_F_MERGE;
          end
        end

        // Split down to the requested order, listing each upper half that lies in the zone.
        S_SPLIT: begin
          if (ord == tgt) begin
            page_out <= pg[PAGE_W-1:0];
            state    <= S_DONE;
          end else begin
            ord <= ord_dn;
            if (in_zone(buddy, zone_lo, zcnt)) begin
              nd    <= buddy_ofs;
              state <= S_PUSH_H;
            end
          end
        end

        // Push node nd onto the head of list ord.
        S_PUSH_H: begin
          link_save <= head[ord];
          head[ord] <= LINK_W'(nd);
          if (head[ord] == NIL) tail[ord] <= LINK_W'(nd);
          state <= S_PUSH_H2;
        end

        S_PUSH_H2: begin
          state <= (cmd_q == CMD_ALLOC) ? S_SPLIT : S_DONE;
        end

        // Free: a page that already heads a free block is left alone.
        S_F_CHK: begin
          state <= flag_rd[FLAG_W-1] ? S_DONE : S_F_MERGE;
        end

        S_F_MERGE: begin
          if (ord == ORD_W'(TOP_ORDER) || !in_zone(buddy, zone_lo, zcnt)) begin
            nd    <= off;
            state <= S_PUSH_H;
          end else begin
            bd    <= buddy;
            nd    <= buddy_ofs;
            ret   <= S_F_BCHK;
            state <= S_WAIT;
          end
        end

        // Merge only with a free buddy of the same order.
        S_F_BCHK: begin
          if (!flag_rd[FLAG_W-1] || flag_rd[ORD_W-1:0] != ord) begin
            nd    <= off;
            state <= S_PUSH_H;
          end else begin
            state <= S_UNLINK;
          end
        end

        // Add range: next maximal aligned block.
        S_ADD_BLK: begin
          ord   <= add_k;
          nd    <= OFS_W'(pg - zone_lo);
          ret   <= S_ADD_CHK;
          state <= S_WAIT;
        end

        S_ADD_CHK: begin
          if (!flag_rd[FLAG_W-1]) begin
            link_save <= tail[ord];
            tail[ord] <= LINK_W'(nd);
            if (tail[ord] == NIL) head[ord] <= LINK_W'(nd);
            state <= S_ADD_T2;
          end else begin
            pg    <= pg_next;
            state <= (pg_next >= end_q) ? S_DONE : S_ADD_BLK;
          end
        end

        S_ADD_T2: begin
          pg    <= pg_next;
          state <= (pg_next >= end_q) ? S_DONE : S_ADD_BLK;
        end

        // Hand the result to the response register once it is free.
        S_DONE: begin
          if (!out_v || rsp.ready) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- tb/sv/tb_buddy_page_allocator_top.sv -----
// Testbench for buddy_page_allocator_top: a scoreboard class predicts every
// response from its own copy of the free lists, and plain tasks drive the block.
// Depends on bpa_pkg, bpa_req_if, bpa_rsp_if and the allocator RTL.
`default_nettype none
module tb_buddy_page_allocator_top;
  import bpa_pkg::*;

  localparam int unsigned NULL_OFS = NUM_PAGES;

  // Predicts each response of the allocator and checks the responses in order.
  class page_scoreboard;
    longint unsigned zone_first;
    longint unsigned zone_count;
    bit [ORD_W-1:0] blk_order[NUM_PAGES];
    bit             is_free[NUM_PAGES];
    int unsigned    nxt[NUM_PAGES];
    int unsigned    prv[NUM_PAGES];
    int unsigned    head[TOP_ORDER+1];
    int unsigned    tail[TOP_ORDER+1];
    logic [1:0]        want_status[$];
    logic [PAGE_W-1:0] want_page[$];
    logic [PAGE_W-1:0] live_page[$];
    int unsigned       live_order[$];
    int errors, checked, n_alloc_ok, n_noblk, n_zone, n_free, n_add;

    function new();
      zone_first = 0;
      zone_count = NUM_PAGES;
      for (int k = 0; k <= TOP_ORDER; k++) begin
        head[k] = NULL_OFS;
        tail[k] = NULL_OFS;
      end
      foreach (is_free[i]) is_free[i] = 0;
    endfunction

    function void set_reg(bit idx, logic [PAGE_W-1:0] v);
      if (idx == CFG_ZONE_FIRST) zone_first = 64'(v);
      else zone_count = 64'(v[CNT_W-1:0]);
      // Blocks handed out under the old zone are no longer useful to free.
      live_page.delete();
      live_order.delete();
    endfunction

    function longint unsigned zone_pages();
      return zone_count < NUM_PAGES ? zone_count : NUM_PAGES;
    endfunction

    function bit in_zone(longint unsigned p);
      return p >= zone_first && p - zone_first < zone_pages();
    endfunction

    function void push_head(int unsigned o, int unsigned k);
      int unsigned h;
      h = head[k];
      prv[o] = NULL_OFS;
      nxt[o] = h;
      if (h < NULL_OFS) prv[h] = o; else tail[k] = o;
      head[k] = o;
    endfunction

    function void push_tail(int unsigned o, int unsigned k);
      int unsigned t;
      t = tail[k];
      nxt[o] = NULL_OFS;
      prv[o] = t;
      if (t < NULL_OFS) nxt[t] = o; else head[k] = o;
      tail[k] = o;
    endfunction

    function void unlink(int unsigned o, int unsigned k);
      int unsigned p, n;
      p = prv[o];
      n = nxt[o];
      if (p < NULL_OFS) nxt[p] = n; else head[k] = n;
      if (n < NULL_OFS) prv[n] = p; else tail[k] = p;
    endfunction

    // Work out the response to one accepted request and queue it.
    function void note_request(logic [1:0] cmd, logic [ORD_W-1:0] order,
                               logic [PAGE_W-1:0] page, logic [END_W-1:0] rend);
      logic [1:0] st;
      logic [PAGE_W-1:0] blk;
      int unsigned cur, o, bo;
      longint unsigned idx, b, p;
      st = ST_OK;
      blk = '0;
      case (cmd)
        CMD_ALLOC: begin
          cur = 32'(order);
          while (cur <= TOP_ORDER && head[cur] >= NULL_OFS) cur++;
          if (order > TOP_ORDER || cur > TOP_ORDER) begin
            st = ST_NOBLK;
          end else begin
            o = head[cur];
            unlink(o, cur);
            is_free[o] = 0;
            idx = zone_first + 64'(o);
            // Split down, pushing each upper half that lies in the zone.
            while (cur != order) begin
              cur--;
              b = idx ^ (64'd1 << cur);
              if (in_zone(b)) begin
                bo = 32'(b - zone_first);
                blk_order[bo] = ORD_W'(cur);
                is_free[bo] = 1;
                push_head(bo, cur);
              end
            end
            blk = idx[PAGE_W-1:0];
            live_page.push_back(blk);
            live_order.push_back(32'(order));
            n_alloc_ok++;
          end
        end
        CMD_FREE: begin
          n_free++;
          idx = 64'(page);
          cur = 32'(order);
          if (!in_zone(idx)) begin
            st = ST_ZONE;
          end else if (order > TOP_ORDER) begin
            st = ST_NOBLK;
          end else begin
            o = 32'(idx - zone_first);
            // A page that already heads a free block is left alone.
            if (!is_free[o]) begin
              while (cur < TOP_ORDER) begin
                b = idx ^ (64'd1 << cur);
                if (!in_zone(b)) break;
                bo = 32'(b - zone_first);
                if (!is_free[bo] || blk_order[bo] != cur) break;
                unlink(bo, cur);
                is_free[bo] = 0;
                cur++;
                if (b < idx) begin
                  idx = b;
                  o = bo;
                end
              end
              blk_order[o] = ORD_W'(cur);
              is_free[o] = 1;
              push_head(o, cur);
            end
          end
        end
        CMD_ADD: begin
          n_add++;
          if (page < rend) begin
            if (!in_zone(64'(page)) || 64'(rend) > zone_first + zone_pages()) begin
              st = ST_ZONE;
            end else begin
              p = 64'(page);
              // Cut the range into maximal aligned blocks, appended at the tails.
              while (p < rend) begin
                cur = 0;
                while (cur < TOP_ORDER) begin
                  if (p[cur]) break;
                  if (p + (64'd1 << (cur + 1)) > rend) break;
                  cur++;
                end
                o = 32'(p - zone_first);
                if (!is_free[o]) begin
                  blk_order[o] = ORD_W'(cur);
                  is_free[o] = 1;
                  push_tail(o, cur);
                end
                p += 64'd1 << cur;
              end
            end
          end
        end
        default: ;
      endcase
      if (st == ST_NOBLK) n_noblk++;
      if (st == ST_ZONE) n_zone++;
      want_status.push_back(st);
      want_page.push_back(blk);
    endfunction

    function void check_response(logic [1:0] st, logic [PAGE_W-1:0] pg);
      logic [1:0] es;
      logic [PAGE_W-1:0] ep;
      checked++;
      if (want_status.size() == 0) begin
        $error("response with no request outstanding: status=%0d block_page=%0h", st, pg);
        errors++;
        return;
      end
      es = want_status.pop_front();
      ep = want_page.pop_front();
      if (st !== es) begin
        $error("status: expected %0d, actual %0d", es, st);
        errors++;
      end
      if (pg !== ep) begin
        $error("block_page: expected %0h, actual %0h", ep, pg);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [PAGE_W-1:0] cfg_wdata = '0;
  bit no_idle = 1'b0;

  bpa_req_if req();
  bpa_rsp_if rsp();

  page_scoreboard sb = new();

  buddy_page_allocator_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .req(req), .rsp(rsp)
  );

  always #5 clk = ~clk;

  initial begin
    req.valid = 1'b0;
    req.cmd = '0;
    req.block_order = '0;
    req.page_index = '0;
    req.range_end = '0;
    rsp.ready = 1'b0;
  end

  // Send one request and note it with the scoreboard when it is accepted.
  task automatic send_request(logic [1:0] cmd, logic [ORD_W-1:0] order,
                              logic [PAGE_W-1:0] page, logic [END_W-1:0] rend);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.block_order <= order;
    req.page_index <= page;
    req.range_end <= rend;
    do @(posedge clk); while (!req.ready);
    sb.note_request(cmd, order, page, rend);
  endtask

  // Drain, then write both zone registers.
  task automatic set_zone(logic [PAGE_W-1:0] first, logic [PAGE_W-1:0] count);
    req.valid <= 1'b0;
    while (sb.want_status.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_ZONE_FIRST;
    cfg_wdata <= first;
    @(posedge clk);
    sb.set_reg(CFG_ZONE_FIRST, first);
    cfg_index <= CFG_ZONE_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    sb.set_reg(CFG_ZONE_COUNT, count);
    cfg_we <= 1'b0;
  endtask

  // Random mix: mostly adds, allocs and frees of live blocks, some noise.
  task automatic random_phase(int n);
    int r, sel;
    longint unsigned cnt, b, e, zend;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      cnt = sb.zone_pages();
      zend = sb.zone_first + cnt;
      if (r < 35 || (r < 65 && sb.live_page.size() == 0)) begin
        send_request(CMD_ALLOC, ORD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, TOP_ORDER)
                                                                    : $urandom_range(0, 3)),
                     '0, '0);
      end else if (r < 65) begin
        sel = $urandom_range(0, sb.live_page.size() - 1);
        send_request(CMD_FREE, ORD_W'(sb.live_order[sel]), sb.live_page[sel], END_W'($urandom));
        sb.live_page.delete(sel);
        sb.live_order.delete(sel);
      end else if (r < 78 && cnt > 0) begin
        b = sb.zone_first + $urandom_range(0, cnt - 1);
        e = b + (($urandom_range(0, 7) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 64));
        if (e > zend) e = zend;
        send_request(CMD_ADD, ORD_W'($urandom), PAGE_W'(b), END_W'(e));
      end else if (r < 88) begin
        send_request(CMD_FREE, ORD_W'($urandom_range(0, TOP_ORDER)),
                     PAGE_W'(sb.zone_first + $urandom_range(0, cnt + 4)), END_W'($urandom));
      end else begin
        send_request(2'($urandom), ORD_W'($urandom), PAGE_W'($urandom), END_W'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  // Response side: random stalls, every response checked in order.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      sb.check_response(rsp.status, rsp.block_page);
    end
  end

  initial begin
    #5000000;
    $display("buddy_page_allocator_top: mismatch");
    $finish;
  end

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_zone(20'd0, 20'd4096);

    // Directed requests on the full zone.
    send_request(CMD_ALLOC, 4'd0, '0, '0);            // empty lists
    send_request(CMD_ALLOC, 4'd15, '0, '0);           // order too large
    send_request(CMD_ADD, 4'd0, 20'd5, 21'd5);        // empty range
    send_request(CMD_ADD, 4'd0, 20'd3, 21'd2);        // reversed range
    send_request(CMD_ADD, 4'd0, 20'd0, 21'd4097);     // end past the zone
    send_request(CMD_ADD, 4'd0, 20'd4096, 21'd4100);  // start outside the zone
    send_request(CMD_ADD, 4'hF, 20'hFFFFF, 21'h1FFFFF);
    send_request(CMD_ADD, 4'd0, 20'd1, 21'd4096);     // unaligned start
    send_request(CMD_ADD, 4'd0, 20'd0, 21'd4096);     // page 0 new, rest already free
    send_request(CMD_ALLOC, 4'd10, '0, '0);
    send_request(CMD_ALLOC, 4'd0, '0, '0);
    send_request(CMD_ALLOC, 4'd11, '0, '0);
    send_request(CMD_FREE, 4'd11, 20'd0, '0);         // order too large
    send_request(CMD_FREE, 4'd0, 20'hFFFFF, '0);      // outside the zone
    send_request(CMD_FREE, 4'd0, 20'd4096, '0);       // just past the zone
    send_request(CMD_FREE, 4'd0, 20'd1, '0);          // page 1, taken by the order-0 allocate above
    send_request(2'd3, 4'hF, 20'hFFFFF, 21'h1FFFFF);  // unknown command
    send_request(CMD_FREE, ORD_W'(sb.live_order[0]), sb.live_page[0], '0);
    send_request(CMD_FREE, ORD_W'(sb.live_order[1]), sb.live_page[1], '0);
    sb.live_page.delete();
    sb.live_order.delete();
    send_request(CMD_ALLOC, 4'd10, '0, '0);
    random_phase(150);

    // Unaligned zone: split halves and buddies fall outside it.
    set_zone(20'h00405, 20'd3000);
    send_request(CMD_ADD, 4'd0, 20'h00405, 21'h00405 + 21'd3000);
    random_phase(100);

    // Zone ending at the top of the page space.
    set_zone(20'hFF800, 20'd2048);
    send_request(CMD_ADD, 4'd0, 20'hFF800, 21'h100000);
    random_phase(80);

    // Largest first page with an oversized count, then an empty zone.
    set_zone(20'hFFFFF, 20'h01FFF);
    send_request(CMD_ADD, 4'd0, 20'hFFFFF, 21'h100000);
    random_phase(80);
    set_zone(20'd0, 20'd0);
    random_phase(20);

    req.valid <= 1'b0;
    waited = 0;
    while (sb.want_status.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    $display("Checked %0d responses: %0d allocations, %0d frees, %0d range adds,",
             sb.checked, sb.n_alloc_ok, sb.n_free, sb.n_add);
    $display("  %0d no-block and %0d out-of-zone statuses over five zone settings.",
             sb.n_noblk, sb.n_zone);
    if (sb.errors == 0 && sb.want_status.size() == 0) begin
      $display("buddy_page_allocator_top: match");
    end else begin
      $display("buddy_page_allocator_top: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
